>>> rtl/jdq_pkg.sv
// ----------------------------------------------------------------------------
// jdq_pkg
// Shared types and constants for the joystick direction quantizer.
// ----------------------------------------------------------------------------
package jdq_pkg;

	// widest configuration register (the two delay registers)
	localparam int CFG_BITS = 16;
	localparam int CFG_INDEX_BITS = 3;

	// register indexes on the configuration port
	localparam logic [CFG_INDEX_BITS-1:0] REG_REST_X = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_REST_Y = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PRESS_THR = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RELEASE_THR = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_DEBOUNCE = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_REPEAT = 3'd5;

	// register reset values
	localparam int RST_CENTER = 2730;
	localparam int RST_PRESS_THR = 800;
	localparam int RST_RELEASE_THR = 400;
	localparam logic [CFG_BITS-1:0] RST_DEBOUNCE = 16'd250;
	localparam logic [CFG_BITS-1:0] RST_REPEAT = 16'd500;

	// request kinds
	localparam logic REQ_POLL = 1'b0;
	localparam logic REQ_BUTTON = 1'b1;

	typedef enum logic [2:0] {
		DIR_REST   = 3'd0,
		DIR_WEST   = 3'd1,
		DIR_EAST   = 3'd2,
		DIR_NORTH  = 3'd3,
		DIR_SOUTH  = 3'd4,
		DIR_BUTTON = 3'd5
	} dir_t;

endpackage

>>> rtl/jdq_cfg.sv
// ----------------------------------------------------------------------------
// jdq_cfg
// Configuration register file: centres, thresholds and delays.
// ----------------------------------------------------------------------------
module jdq_cfg
	import jdq_pkg::*;
#(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]       cfg_wdata,
	output logic [SAMPLE_BITS-1:0]    rest_x,
	output logic [SAMPLE_BITS-1:0]    rest_y,
	output logic [SAMPLE_BITS-1:0]    press_thr,
	output logic [SAMPLE_BITS-1:0]    release_thr,
	output logic [CFG_BITS-1:0]       debounce_ms,
	output logic [CFG_BITS-1:0]       repeat_ms
);

	logic [SAMPLE_BITS-1:0] rest_x_q;
	logic [SAMPLE_BITS-1:0] rest_y_q;
	logic [SAMPLE_BITS-1:0] press_thr_q;
	logic [SAMPLE_BITS-1:0] release_thr_q;
	logic [CFG_BITS-1:0]    debounce_q;
	logic [CFG_BITS-1:0]    repeat_q;
	logic [SAMPLE_BITS-1:0] wdata_sample;

	assign wdata_sample = cfg_wdata[SAMPLE_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rest_x_q      <= SAMPLE_BITS'(RST_CENTER);
			rest_y_q      <= SAMPLE_BITS'(RST_CENTER);
			press_thr_q   <= SAMPLE_BITS'(RST_PRESS_THR);
			release_thr_q <= SAMPLE_BITS'(RST_RELEASE_THR);
			debounce_q    <= RST_DEBOUNCE;
			repeat_q      <= RST_REPEAT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_REST_X:      rest_x_q      <= wdata_sample;
				REG_REST_Y:      rest_y_q      <= wdata_sample;
				REG_PRESS_THR:   press_thr_q   <= wdata_sample;
				REG_RELEASE_THR: release_thr_q <= wdata_sample;
				REG_DEBOUNCE:    debounce_q    <= cfg_wdata;
				REG_REPEAT:      repeat_q      <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign rest_x      = rest_x_q;
	assign rest_y      = rest_y_q;
	assign press_thr   = press_thr_q;
	assign release_thr = release_thr_q;
	assign debounce_ms = debounce_q;
	assign repeat_ms   = repeat_q;

endmodule

>>> rtl/jdq_classify.sv
// ----------------------------------------------------------------------------
// jdq_classify
// Maps one X/Y sample pair to a direction, with press/release hysteresis.
// ----------------------------------------------------------------------------
module jdq_classify
	import jdq_pkg::*;
#(
	parameter int SAMPLE_BITS = 12
) (
	input  logic [SAMPLE_BITS-1:0] x_sample,
	input  logic [SAMPLE_BITS-1:0] y_sample,
	input  logic [SAMPLE_BITS-1:0] rest_x,
	input  logic [SAMPLE_BITS-1:0] rest_y,
	input  logic [SAMPLE_BITS-1:0] press_thr,
	input  logic [SAMPLE_BITS-1:0] release_thr,
	input  dir_t                   prev,
	output dir_t                   dir
);

	// two guard bits: sign plus headroom for centre + threshold
	localparam int SW = SAMPLE_BITS + 2;

	logic signed [SW-1:0] xs, ys, cxs, cys, pts, rts;
	logic signed [SW-1:0] dx, dy, ax, ay;
	logic x_lo_p, x_hi_p, x_lo_r, x_hi_r;
	logic y_lo_p, y_hi_p, y_lo_r, y_hi_r;
	logic near_centre;

	always_comb begin
		xs  = $signed({2'b00, x_sample});
		ys  = $signed({2'b00, y_sample});
		cxs = $signed({2'b00, rest_x});
		cys = $signed({2'b00, rest_y});
		pts = $signed({2'b00, press_thr});
		rts = $signed({2'b00, release_thr});

		dx = xs - cxs;
		dy = ys - cys;
		ax = (dx < 0) ? -dx : dx;
		ay = (dy < 0) ? -dy : dy;

		near_centre = (ax < rts) && (ay < rts);

		x_lo_p = xs < (cxs - pts);
		x_hi_p = xs > (cxs + pts);
		x_lo_r = xs < (cxs - rts);
		x_hi_r = xs > (cxs + rts);
		y_lo_p = ys < (cys - pts);
		y_hi_p = ys > (cys + pts);
		y_lo_r = ys < (cys - rts);
		y_hi_r = ys > (cys + rts);

		dir = DIR_REST;
		if (near_centre) begin
			dir = DIR_REST;
		end else if (ax > ay) begin
			if (x_lo_p) begin
				dir = DIR_WEST;
			end else if (x_hi_p) begin
				dir = DIR_EAST;
			end else if (prev == DIR_WEST && x_lo_r) begin
				dir = DIR_WEST;
			end else if (prev == DIR_EAST && x_hi_r) begin
				dir = DIR_EAST;
			end else if (prev == DIR_WEST || prev == DIR_EAST) begin
				dir = prev;
			end
		end else begin
			// a tie goes to the Y axis
			if (y_hi_p) begin
				dir = DIR_SOUTH;
			end else if (y_lo_p) begin
				dir = DIR_NORTH;
			end else if (prev == DIR_SOUTH && y_hi_r) begin
				dir = DIR_SOUTH;
			end else if (prev == DIR_NORTH && y_lo_r) begin
				dir = DIR_NORTH;
			end else if (prev == DIR_SOUTH || prev == DIR_NORTH) begin
				dir = prev;
			end
		end
	end

endmodule

>>> rtl/joystick_direction_quantizer.sv
// ----------------------------------------------------------------------------
// joystick_direction_quantizer
// Joystick poll/button requests in, one quantised direction result out.
// ----------------------------------------------------------------------------
//
//  channel  | handshake           | payload
//  ---------+---------------------+--------------------------------------------
//  request  | req_valid/req_stall | req_type, x_sample, y_sample, now_ms
//  result   | rsp_valid/rsp_stall | direction, event_fired, button_accepted
//  config   | cfg_we              | cfg_index, cfg_wdata
//
// one request per clock while the result is not stalled; a request passes
// the request register, then the result register with the state update
// direction, event timer and pending button are updated as a request moves
// into the result register, so the following request sees them at once
// reset clears the valid flags and block state and presets the configuration
// a stalled result holds the request register, which then stalls the input
//
module joystick_direction_quantizer
	import jdq_pkg::*;
#(
	parameter int SAMPLE_BITS = 12,
	parameter int TIME_BITS = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// request channel
	input  logic                      req_valid,
	output logic                      req_stall,
	input  logic                      req_type,
	input  logic [SAMPLE_BITS-1:0]    x_sample,
	input  logic [SAMPLE_BITS-1:0]    y_sample,
	input  logic [TIME_BITS-1:0]      now_ms,
	// result channel
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output logic [2:0]                direction,
	output logic                      event_fired,
	output logic                      button_accepted,
	// configuration
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]       cfg_wdata
);

	logic [SAMPLE_BITS-1:0] rest_x, rest_y, press_thr, release_thr;
	logic [CFG_BITS-1:0]    debounce_ms, repeat_ms;

	// request register
	logic                   valid_s1;
	logic                   req_type_s1;
	logic [SAMPLE_BITS-1:0] x_s1, y_s1;
	logic [TIME_BITS-1:0]   now_s1;

	// block state
	dir_t                   last_dir_q;
	logic [TIME_BITS-1:0]   last_time_q;
	logic                   pending_q;

	// result register
	logic                   rsp_valid_q;
	dir_t                   dir_q;
	logic                   fired_q;
	logic                   accepted_q;

	logic                   advance;
	logic                   take_req;
	dir_t                   poll_dir;
	logic [TIME_BITS-1:0]   elapsed;
	logic                   past_input, past_repeat;

	dir_t                   dir_n, last_dir_n;
	logic                   fired_n, accepted_n, pending_n, stamp;

	jdq_cfg #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.rest_x      (rest_x),
		.rest_y      (rest_y),
		.press_thr   (press_thr),
		.release_thr (release_thr),
		.debounce_ms (debounce_ms),
		.repeat_ms   (repeat_ms)
	);

	jdq_classify #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_classify (
		.x_sample    (x_s1),
		.y_sample    (y_s1),
		.rest_x      (rest_x),
		.rest_y      (rest_y),
		.press_thr   (press_thr),
		.release_thr (release_thr),
		.prev        (last_dir_q),
		.dir         (poll_dir)
	);

	assign advance   = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign take_req  = req_valid && !req_stall;
	assign req_stall = valid_s1 && !advance;

	// elapsed time wraps with the time stamp
	assign elapsed     = now_s1 - last_time_q;
	assign past_input  = elapsed > TIME_BITS'(debounce_ms);
	assign past_repeat = elapsed > TIME_BITS'(repeat_ms);

	always_comb begin
		dir_n      = last_dir_q;
		last_dir_n = last_dir_q;
		fired_n    = 1'b0;
		accepted_n = 1'b0;
		pending_n  = pending_q;
		stamp      = 1'b0;
		if (req_type_s1 == REQ_BUTTON) begin
			// debounce against the last recorded event
			if (past_input) begin
				pending_n  = 1'b1;
				accepted_n = 1'b1;
				stamp      = 1'b1;
			end
		end else if (pending_q) begin
			pending_n  = 1'b0;
			last_dir_n = DIR_BUTTON;
			dir_n      = DIR_BUTTON;
		end else begin
			last_dir_n = poll_dir;
			dir_n      = poll_dir;
			if (poll_dir != DIR_REST) begin
				if (last_dir_q == DIR_REST && past_input) begin
					stamp   = 1'b1;
					fired_n = 1'b1;
				end else if (poll_dir == last_dir_q && past_repeat) begin
					stamp   = 1'b1;
					fired_n = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_req) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_req) begin
			req_type_s1 <= req_type;
			x_s1        <= x_sample;
			y_s1        <= y_sample;
			now_s1      <= now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_dir_q  <= DIR_REST;
			last_time_q <= '0;
			pending_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				last_dir_q <= last_dir_n;
				pending_q  <= pending_n;
				if (stamp) begin
					last_time_q <= now_s1;
				end
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			dir_q      <= dir_n;
			fired_q    <= fired_n;
			accepted_q <= accepted_n;
		end
	end

	assign rsp_valid       = rsp_valid_q;
	assign direction       = dir_q;
	assign event_fired     = fired_q;
	assign button_accepted = accepted_q;

endmodule
